// ===== hw/rtl/rrts_pkg.sv =====
// Shared types and constants for the round-robin task scheduler.
package rrts_pkg;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] duration_ms;
  } in_word_t;

  typedef struct packed {
    logic [2:0] run_task;
    logic       no_task;
    logic [2:0] new_index;
    logic       status;
    logic [3:0] task_count;
  } out_word_t;

  typedef struct packed {
    logic capture;
    logic do_create;
    logic do_sleep_wr;
    logic do_end_wr;
    logic walk_init_cd;
    logic walk_init_pk;
    logic walk_cd;
    logic walk_pk;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic has_cur;
    logic walk_done;
    logic pick_hit;
  } dp_stat_t;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_CREATE = 2'd1;
  localparam logic [1:0] ACT_SLEEP  = 2'd2;
  localparam logic [1:0] ACT_END    = 2'd3;

  localparam logic [2:0] TS_INVALID    = 3'd0;
  localparam logic [2:0] TS_READY      = 3'd1;
  localparam logic [2:0] TS_RUNNING    = 3'd2;
  localparam logic [2:0] TS_SLEEPING   = 3'd3;
  localparam logic [2:0] TS_TERMINATED = 3'd4;

  localparam logic [15:0] TPS_RESET = 16'd2000;

  // x/1000 = floor((x>>3) * RECIP_125 / 2^DIV_SHIFT), exact for x below 2^32
  localparam logic [29:0] RECIP_125 = 30'd549755814;
  localparam int unsigned DIV_SHIFT = 36;

endpackage

// ===== hw/rtl/rrts_dp.sv =====
// Scheduler datapath: task table memories, ms-to-tick conversion, table walker.
module rrts_dp #(
  parameter int MAX_TASKS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rrts_pkg::in_word_t  in_word,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  rrts_pkg::dp_cmd_t   cmd,
  output rrts_pkg::dp_stat_t  stat,
  output rrts_pkg::out_word_t out_word
);

  localparam int IDXW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int NUMW = $clog2(MAX_TASKS + 1);

  // task table
  logic [2:0]  st_mem    [MAX_TASKS];
  logic [15:0] slice_mem [MAX_TASKS];
  logic [15:0] used_mem  [MAX_TASKS];
  logic [15:0] sleep_mem [MAX_TASKS];

  logic [2:0]  st_q;
  logic [15:0] slice_q, used_q, sleep_q;

  logic [IDXW-1:0] rd_addr, wr_addr;
  logic            we_st, we_slice, we_used, we_sleep;
  logic [2:0]      st_wd;
  logic [15:0]     slice_wd, used_wd, sleep_wd;

  // control state
  logic [15:0]     tps_r;
  logic [NUMW-1:0] num_r;
  logic [IDXW-1:0] cur_r;
  logic            idle_r;
  logic [IDXW-1:0] new_idx_r;
  logic            status_r;
  rrts_pkg::in_word_t in_r;

  // conversion pipeline
  logic [31:0] prod1_r;
  logic [58:0] prod2;
  logic [15:0] ticks_r;

  // walker
  logic [IDXW-1:0] iss_ptr_r, proc_ptr_r, ptr_nxt, pk_start;
  logic [NUMW-1:0] cnt_r;
  logic            proc_v_r, proc_last_r;
  logic            issue;
  logic [NUMW:0]   ptr_inc, cnt_inc;

  logic [15:0] u1, s1;
  logic        is_run, is_ready, is_sleep, under_slice;
  logic        full, has_cur, pick_hit, walk_done;

  logic [IDXW+2:0] cur_ext, new_ext;
  logic [NUMW+3:0] num_ext;

  always_comb begin
    full      = num_r >= NUMW'(MAX_TASKS);
    has_cur   = !idle_r && (NUMW'(cur_r) < num_r);
    pk_start  = (NUMW'(cur_r) < num_r) ? cur_r : '0;
    ptr_inc   = (NUMW + 1)'(iss_ptr_r) + 1'b1;
    ptr_nxt   = (ptr_inc >= {1'b0, num_r}) ? '0 : ptr_inc[IDXW-1:0];
    cnt_inc   = (NUMW + 1)'(cnt_r) + 1'b1;
    issue     = (cmd.walk_cd || cmd.walk_pk) && (cnt_r < num_r);
    rd_addr   = iss_ptr_r;

    u1          = used_q + 16'd1;
    s1          = sleep_q - 16'd1;
    is_run      = st_q == rrts_pkg::TS_RUNNING;
    is_ready    = st_q == rrts_pkg::TS_READY;
    is_sleep    = st_q == rrts_pkg::TS_SLEEPING;
    under_slice = u1 < slice_q;
    pick_hit    = cmd.walk_pk && proc_v_r && (is_ready || (is_run && under_slice));
    walk_done   = (proc_v_r && proc_last_r) || (num_r == '0);
  end

  always_comb begin
    stat.full      = full;
    stat.has_cur   = has_cur;
    stat.walk_done = walk_done;
    stat.pick_hit  = pick_hit;
  end

  // table write port: one entry per cycle
  always_comb begin
    wr_addr  = proc_ptr_r;
    we_st    = 1'b0;
    we_slice = 1'b0;
    we_used  = 1'b0;
    we_sleep = 1'b0;
    st_wd    = rrts_pkg::TS_READY;
    slice_wd = ticks_r;
    used_wd  = 16'd0;
    sleep_wd = 16'd0;
    if (cmd.do_create) begin
      wr_addr  = num_r[IDXW-1:0];
      we_st    = 1'b1;
      we_slice = 1'b1;
      we_used  = 1'b1;
      we_sleep = 1'b1;
    end else if (cmd.do_sleep_wr) begin
      wr_addr  = cur_r;
      we_st    = 1'b1;
      st_wd    = rrts_pkg::TS_SLEEPING;
      we_sleep = 1'b1;
      sleep_wd = ticks_r;
    end else if (cmd.do_end_wr) begin
      wr_addr = cur_r;
      we_st   = 1'b1;
      st_wd   = rrts_pkg::TS_TERMINATED;
    end else if (cmd.walk_cd && proc_v_r && is_sleep) begin
      we_sleep = 1'b1;
      sleep_wd = s1;
      we_st    = s1 == 16'd0;
    end else if (cmd.walk_pk && proc_v_r) begin
      if (is_run) begin
        we_used = 1'b1;
        used_wd = u1;
        we_st   = !under_slice;
      end else if (is_ready) begin
        we_used = 1'b1;
        we_st   = 1'b1;
        st_wd   = rrts_pkg::TS_RUNNING;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we_st) begin
      st_mem[wr_addr] <= st_wd;
    end
    if (we_slice) begin
      slice_mem[wr_addr] <= slice_wd;
    end
    if (we_used) begin
      used_mem[wr_addr] <= used_wd;
    end
    if (we_sleep) begin
      sleep_mem[wr_addr] <= sleep_wd;
    end
    st_q    <= st_mem[rd_addr];
    slice_q <= slice_mem[rd_addr];
    used_q  <= used_mem[rd_addr];
    sleep_q <= sleep_mem[rd_addr];
  end

  // ms to ticks: rate * ms, then divide by 1000 through a reciprocal
  assign prod2 = 59'(prod1_r[31:3]) * 59'(rrts_pkg::RECIP_125);

  always_ff @(posedge clk) begin
    prod1_r <= 32'(tps_r) * 32'(in_r.duration_ms);
    ticks_r <= prod2[rrts_pkg::DIV_SHIFT+15:rrts_pkg::DIV_SHIFT];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r      <= in_word;
      new_idx_r <= '0;
      status_r  <= (in_word.action == rrts_pkg::ACT_CREATE) && full;
    end else if (cmd.do_create) begin
      new_idx_r <= num_r[IDXW-1:0];
    end
    if (issue) begin
      proc_ptr_r  <= iss_ptr_r;
      proc_last_r <= cnt_inc == {1'b0, num_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r     <= rrts_pkg::TPS_RESET;
      num_r     <= '0;
      cur_r     <= '0;
      idle_r    <= 1'b0;
      iss_ptr_r <= '0;
      cnt_r     <= '0;
      proc_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        tps_r <= cfg_wdata;
      end
      if (cmd.do_create) begin
        num_r <= num_r + 1'b1;
      end
      if (pick_hit) begin
        cur_r  <= proc_ptr_r;
        idle_r <= 1'b0;
      end else if (cmd.walk_pk && walk_done) begin
        // nothing ready: go idle, restart the next search at entry 0
        cur_r  <= '0;
        idle_r <= 1'b1;
      end
      if (cmd.walk_init_cd || cmd.walk_init_pk) begin
        iss_ptr_r <= cmd.walk_init_pk ? pk_start : '0;
        cnt_r     <= '0;
        proc_v_r  <= 1'b0;
      end else begin
        proc_v_r <= issue;
        if (issue) begin
          iss_ptr_r <= ptr_nxt;
          cnt_r     <= cnt_inc[NUMW-1:0];
        end
      end
    end
  end

  always_comb begin
    cur_ext             = (IDXW + 3)'(cur_r);
    new_ext             = (IDXW + 3)'(new_idx_r);
    num_ext             = (NUMW + 4)'(num_r);
    out_word.run_task   = cur_ext[2:0];
    out_word.no_task    = idle_r;
    out_word.new_index  = new_ext[2:0];
    out_word.status     = status_r;
    out_word.task_count = num_ext[3:0];
  end

endmodule

// ===== hw/rtl/rrts_ctrl.sv =====
// Scheduler controller: sequences create, sleep, end and tick passes.
module rrts_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_action,
  input  rrts_pkg::dp_stat_t stat,
  output rrts_pkg::dp_cmd_t  cmd,
  output logic               busy,
  output logic               out_valid
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL1    = 4'd1;
  localparam logic [3:0] S_MUL2    = 4'd2;
  localparam logic [3:0] S_CREATE  = 4'd3;
  localparam logic [3:0] S_SLEEPW  = 4'd4;
  localparam logic [3:0] S_ENDW    = 4'd5;
  localparam logic [3:0] S_INIT_CD = 4'd6;
  localparam logic [3:0] S_CD      = 4'd7;
  localparam logic [3:0] S_INIT_PK = 4'd8;
  localparam logic [3:0] S_PK      = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic [1:0] act_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.capture = start;
        if (start) begin
          case (in_action)
            rrts_pkg::ACT_TICK:   state_nxt = S_INIT_CD;
            rrts_pkg::ACT_CREATE: state_nxt = stat.full ? S_DONE : S_MUL1;
            rrts_pkg::ACT_SLEEP:  state_nxt = stat.has_cur ? S_MUL1 : S_INIT_CD;
            default:              state_nxt = stat.has_cur ? S_ENDW : S_DONE;
          endcase
        end
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = (act_r == rrts_pkg::ACT_CREATE) ? S_CREATE : S_SLEEPW;
      S_CREATE: begin
        cmd.do_create = 1'b1;
        state_nxt     = S_DONE;
      end
      S_SLEEPW: begin
        cmd.do_sleep_wr = 1'b1;
        state_nxt       = S_INIT_CD;
      end
      S_ENDW: begin
        cmd.do_end_wr = 1'b1;
        state_nxt     = S_DONE;
      end
      S_INIT_CD: begin
        cmd.walk_init_cd = 1'b1;
        state_nxt        = S_CD;
      end
      S_CD: begin
        cmd.walk_cd = 1'b1;
        if (stat.walk_done) begin
          state_nxt = S_INIT_PK;
        end
      end
      S_INIT_PK: begin
        cmd.walk_init_pk = 1'b1;
        state_nxt        = S_PK;
      end
      S_PK: begin
        cmd.walk_pk = 1'b1;
        if (stat.pick_hit || stat.walk_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_action;
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = state_r == S_DONE;

endmodule

// ===== hw/rtl/round_robin_task_scheduler_top.sv =====
// Throughput: one word at a time; a create on a full table skips the conversion and write.
// Tick and sleep words walk the task table twice (one entry per cycle through the
//   table's read port), once to count down sleepers and once to pick the next task.
// The result strobe lasts one cycle and cannot be held off; busy drops the cycle after.
// Reset clears control state and sets the tick rate to 2000; no clearing pass.
module round_robin_task_scheduler_top #(
  parameter int MAX_TASKS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  rrts_pkg::in_word_t  in_word,
  output logic                out_valid,
  output rrts_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);

  rrts_pkg::dp_cmd_t  cmd;
  rrts_pkg::dp_stat_t stat;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_word.action),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  rrts_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_word  (out_word)
  );

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_strobe_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe outside a busy period");

  a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status |-> out_word.new_index == 3'd0)
    else $error("full table reported with a nonzero index");

endmodule

// ===== tb/sv/tb_round_robin_task_scheduler_top.sv =====
// Self-checking testbench for the round-robin task scheduler top level.
module tb_round_robin_task_scheduler_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TASK_SLOTS   = 8;
  localparam int MS_PER_SEC   = 1000;
  localparam int WATCHDOG_MAX = 1000;
  localparam int TAIL_CYCLES  = 2 * TASK_SLOTS + 12;
  localparam int PHASE_WORDS  = 200;
  localparam int NUM_PHASES   = 8;
  localparam logic [15:0] LONG_SLEEP = 16'd2000;

  typedef enum logic {ROW_WORD, ROW_RATE} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    rrts_pkg::in_word_t  word;
    logic [15:0]         rate_v;
    bit                  known;
    rrts_pkg::out_word_t want;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  rrts_pkg::in_word_t  in_word = '0;
  logic                out_valid;
  rrts_pkg::out_word_t out_word;
  logic                cfg_we = 1'b0;
  logic [15:0]         cfg_wdata = '0;

  // scheduler shadow state
  logic [15:0] tick_rate;
  logic [2:0]  slot_state [TASK_SLOTS];
  logic [15:0] slot_slice [TASK_SLOTS];
  logic [15:0] slot_used  [TASK_SLOTS];
  logic [15:0] slot_sleep [TASK_SLOTS];
  int unsigned task_total;
  int unsigned cur_slot;
  bit          sched_idle;

  rrts_pkg::out_word_t decisions_q[$];
  stim_row_t           directed_rows[$];
  int                  fails = 0;
  int                  quiet = 0;
  rrts_pkg::out_word_t head;

  round_robin_task_scheduler_top #(.MAX_TASKS(TASK_SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic logic [15:0] ms_to_ticks(logic [15:0] ms);
    longint unsigned prod;
    prod = 64'(tick_rate) * 64'(ms);
    return 16'(prod / MS_PER_SEC);
  endfunction

  function automatic void tick_pass();
    int unsigned i;
    int unsigned n;
    int unsigned pos;
    for (i = 0; i < task_total; i++) begin
      if (slot_state[i] == rrts_pkg::TS_SLEEPING) begin
        slot_sleep[i] = slot_sleep[i] - 16'd1;
        if (slot_sleep[i] == 16'd0) slot_state[i] = rrts_pkg::TS_READY;
      end
    end
    pos = cur_slot;
    for (n = 0; n < task_total; n++) begin
      if (pos >= task_total) pos = 0;
      if (slot_state[pos] == rrts_pkg::TS_RUNNING) begin
        slot_used[pos] = slot_used[pos] + 16'd1;
        if (slot_used[pos] < slot_slice[pos]) begin
          cur_slot = pos;
          sched_idle = 1'b0;
          return;
        end
        // slice spent: hand the CPU on
        slot_state[pos] = rrts_pkg::TS_READY;
      end else if (slot_state[pos] == rrts_pkg::TS_READY) begin
        slot_used[pos] = 16'd0;
        slot_state[pos] = rrts_pkg::TS_RUNNING;
        cur_slot = pos;
        sched_idle = 1'b0;
        return;
      end
      pos++;
    end
    cur_slot = 0;
    sched_idle = 1'b1;
  endfunction

  function automatic bit has_current();
    return !sched_idle && cur_slot < task_total;
  endfunction

  function automatic rrts_pkg::out_word_t schedule_step(rrts_pkg::in_word_t w);
    rrts_pkg::out_word_t o;
    logic [2:0] new_slot;
    logic       full;
    new_slot = '0;
    full = 1'b0;
    case (w.action)
      rrts_pkg::ACT_TICK: tick_pass();
      rrts_pkg::ACT_CREATE: begin
        if (task_total >= TASK_SLOTS) begin
          full = 1'b1;
        end else begin
          new_slot = task_total[2:0];
          slot_slice[task_total] = ms_to_ticks(w.duration_ms);
          slot_used[task_total] = '0;
          slot_sleep[task_total] = '0;
          slot_state[task_total] = rrts_pkg::TS_READY;
          task_total++;
        end
      end
      rrts_pkg::ACT_SLEEP: begin
        if (has_current()) begin
          slot_sleep[cur_slot] = ms_to_ticks(w.duration_ms);
          slot_state[cur_slot] = rrts_pkg::TS_SLEEPING;
        end
        tick_pass();
      end
      rrts_pkg::ACT_END: begin
        if (has_current()) slot_state[cur_slot] = rrts_pkg::TS_TERMINATED;
      end
      default: ;
    endcase
    o.run_task = cur_slot[2:0];
    o.no_task = sched_idle;
    o.new_index = new_slot;
    o.status = full;
    o.task_count = task_total[3:0];
    return o;
  endfunction

  // tasks that can still be scheduled within a reasonable number of ticks
  function automatic int awake_tasks();
    int unsigned i;
    int cnt;
    cnt = 0;
    for (i = 0; i < task_total; i++) begin
      if (slot_state[i] == rrts_pkg::TS_READY || slot_state[i] == rrts_pkg::TS_RUNNING ||
          (slot_state[i] == rrts_pkg::TS_SLEEPING && slot_sleep[i] < 16'd4096))
        cnt++;
    end
    return cnt;
  endfunction

  function automatic stim_row_t word_row(logic [1:0] act, logic [15:0] ms);
    stim_row_t r;
    r.kind = ROW_WORD;
    r.word.action = act;
    r.word.duration_ms = ms;
    r.rate_v = '0;
    r.known = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [1:0] act, logic [15:0] ms, logic [2:0] run,
                                          logic idle_v, logic [2:0] ni, logic st,
                                          logic [3:0] cnt);
    stim_row_t r;
    r = word_row(act, ms);
    r.known = 1'b1;
    r.want.run_task = run;
    r.want.no_task = idle_v;
    r.want.new_index = ni;
    r.want.status = st;
    r.want.task_count = cnt;
    return r;
  endfunction

  function automatic stim_row_t rate_row(logic [15:0] v);
    stim_row_t r;
    r = word_row(rrts_pkg::ACT_TICK, '0);
    r.kind = ROW_RATE;
    r.rate_v = v;
    return r;
  endfunction

  function automatic void check_field(string name, logic [3:0] want_v, logic [3:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fails++;
    end
  endfunction

  // Present a word, hold it until taken, then record what it must produce.
  task automatic send_word(rrts_pkg::in_word_t w, bit known, rrts_pkg::out_word_t want);
    rrts_pkg::out_word_t pred;
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    pred = schedule_step(w);
    decisions_q.push_back(known ? want : pred);
  endtask

  task automatic idle_for(int n);
    start <= 1'b0;
    in_word <= rrts_pkg::in_word_t'(18'($urandom));
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (decisions_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_rate(logic [15:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tick_rate = v;
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet = 0;
    end else begin
      if ((start && !busy) || out_valid) quiet = 0;
      else quiet++;
      if (out_valid) begin
        if (decisions_q.size() == 0) begin
          $error("result word with nothing expected");
          fails++;
        end else begin
          head = decisions_q.pop_front();
          check_field("run_task", 4'(head.run_task), 4'(out_word.run_task));
          check_field("no_task", 4'(head.no_task), 4'(out_word.no_task));
          check_field("new_index", 4'(head.new_index), 4'(out_word.new_index));
          check_field("status", 4'(head.status), 4'(out_word.status));
          check_field("task_count", head.task_count, out_word.task_count);
        end
      end
      if (quiet >= WATCHDOG_MAX) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t          row;
    rrts_pkg::in_word_t w;
    logic [15:0]        phase_rate [NUM_PHASES];
    logic [15:0]        ms;
    logic [15:0]        ticks;
    int                 r;
    int                 gap;
    int                 ph;
    int                 k;
    bit                 gaps_on;

    tick_rate = rrts_pkg::TPS_RESET;
    task_total = 0;
    cur_slot = 0;
    sched_idle = 1'b0;
    for (k = 0; k < TASK_SLOTS; k++) begin
      slot_state[k] = rrts_pkg::TS_INVALID;
      slot_slice[k] = '0;
      slot_used[k] = '0;
      slot_sleep[k] = '0;
    end

    // empty table, then fill it under several tick rates
    directed_rows.push_back(known_row(rrts_pkg::ACT_TICK,   16'd0,
                                      3'd0, 1'b1, 3'd0, 1'b0, 4'd0));
    directed_rows.push_back(known_row(rrts_pkg::ACT_SLEEP,  16'hFFFF,
                                      3'd0, 1'b1, 3'd0, 1'b0, 4'd0));
    directed_rows.push_back(known_row(rrts_pkg::ACT_END,    16'hFFFF,
                                      3'd0, 1'b1, 3'd0, 1'b0, 4'd0));
    directed_rows.push_back(known_row(rrts_pkg::ACT_CREATE, 16'd0,
                                      3'd0, 1'b1, 3'd0, 1'b0, 4'd1));
    directed_rows.push_back(known_row(rrts_pkg::ACT_CREATE, 16'hFFFF,
                                      3'd0, 1'b1, 3'd1, 1'b0, 4'd2));
    directed_rows.push_back(known_row(rrts_pkg::ACT_CREATE, 16'd1,
                                      3'd0, 1'b1, 3'd2, 1'b0, 4'd3));
    directed_rows.push_back(rate_row(16'd1));
    directed_rows.push_back(known_row(rrts_pkg::ACT_CREATE, 16'hFFFF,
                                      3'd0, 1'b1, 3'd3, 1'b0, 4'd4));
    directed_rows.push_back(rate_row(16'hFFFF));
    directed_rows.push_back(known_row(rrts_pkg::ACT_CREATE, 16'd3,
                                      3'd0, 1'b1, 3'd4, 1'b0, 4'd5));
    directed_rows.push_back(rate_row(16'd0));
    directed_rows.push_back(known_row(rrts_pkg::ACT_CREATE, 16'd12345,
                                      3'd0, 1'b1, 3'd5, 1'b0, 4'd6));
    directed_rows.push_back(rate_row(rrts_pkg::TPS_RESET));
    directed_rows.push_back(known_row(rrts_pkg::ACT_CREATE, 16'd5,
                                      3'd0, 1'b1, 3'd6, 1'b0, 4'd7));
    directed_rows.push_back(known_row(rrts_pkg::ACT_CREATE, 16'd2,
                                      3'd0, 1'b1, 3'd7, 1'b0, 4'd8));
    directed_rows.push_back(known_row(rrts_pkg::ACT_CREATE, 16'hAAAA,
                                      3'd0, 1'b1, 3'd0, 1'b1, 4'd8));
    // slices, zero-length sleep, end of the running task
    directed_rows.push_back(word_row(rrts_pkg::ACT_TICK,  16'd0));
    directed_rows.push_back(word_row(rrts_pkg::ACT_TICK,  16'hFFFF));
    directed_rows.push_back(word_row(rrts_pkg::ACT_TICK,  16'd0));
    directed_rows.push_back(word_row(rrts_pkg::ACT_SLEEP, 16'd0));
    directed_rows.push_back(word_row(rrts_pkg::ACT_TICK,  16'd0));
    directed_rows.push_back(word_row(rrts_pkg::ACT_END,   16'd0));
    directed_rows.push_back(word_row(rrts_pkg::ACT_TICK,  16'd0));
    directed_rows.push_back(word_row(rrts_pkg::ACT_SLEEP, 16'h5555));
    directed_rows.push_back(word_row(rrts_pkg::ACT_SLEEP, 16'd3));
    for (k = 0; k < 4; k++) directed_rows.push_back(word_row(rrts_pkg::ACT_TICK, 16'd0));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_RATE) write_rate(row.rate_v);
      else send_word(row.word, row.known, row.want);
      if (row.kind == ROW_WORD && $urandom_range(0, 2) == 0) idle_for($urandom_range(1, 3));
    end

    phase_rate = '{16'd1000, 16'd2000, 16'd100, 16'hFFFF, 16'd0, 16'd500, 16'd1, 16'd0};
    phase_rate[4] = 16'($urandom_range(2, 65534));

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      write_rate(phase_rate[ph]);
      gaps_on = (ph % 2) == 0;
      for (k = 0; k < PHASE_WORDS; k++) begin
        ms = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
        r = $urandom_range(0, 99);
        if (r < 55) w.action = rrts_pkg::ACT_TICK;
        else if (r < 63) w.action = rrts_pkg::ACT_CREATE;
        else if (r < 85) w.action = rrts_pkg::ACT_SLEEP;
        else w.action = rrts_pkg::ACT_END;
        w.duration_ms = ms;
        // keep a few tasks alive so the round robin stays busy
        ticks = ms_to_ticks(ms);
        if (w.action == rrts_pkg::ACT_SLEEP && awake_tasks() <= 3 &&
            (ticks == 16'd0 || ticks >= LONG_SLEEP))
          w.action = rrts_pkg::ACT_TICK;
        if (w.action == rrts_pkg::ACT_END && awake_tasks() <= 3 && ph != NUM_PHASES - 1)
          w.action = rrts_pkg::ACT_TICK;
        send_word(w, 1'b0, '0);
        if ($urandom_range(0, 127) == 0) begin
          drain_results();
        end else if (gaps_on) begin
          r = $urandom_range(0, 99);
          if (r < 50) gap = 0;
          else if (r < 90) gap = $urandom_range(1, 3);
          else gap = $urandom_range(8, 40);
          if (gap > 0) idle_for(gap);
        end
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fails == 0 && decisions_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rrts_pkg.sv
hw/rtl/rrts_dp.sv
hw/rtl/rrts_ctrl.sv
hw/rtl/round_robin_task_scheduler_top.sv
tb/sv/tb_round_robin_task_scheduler_top.sv
